// ----- hdl/altitude_trend_detector_unit_macros.svh -----
// Assertion helpers used by the RTL file atd_trend.sv.
`ifndef ALTITUDE_TREND_DETECTOR_UNIT_MACROS_SVH
`define ALTITUDE_TREND_DETECTOR_UNIT_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define ATD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ATD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ATD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/atd_pkg.sv -----
`default_nettype none

package atd_pkg;

    localparam int WINDOW   = 8;                 // samples in the window, 2..64
    localparam int PAIRS    = WINDOW - 1;        // neighbor pairs in the window
    localparam int CNT_W    = $clog2(WINDOW);    // holds 0..WINDOW-1
    localparam int SAMPLE_W = 32;
    localparam int THR_W    = 8;
    localparam int RUN_W    = 8;

    localparam logic [RUN_W-1:0] RUN_MAX   = 8'd255;
    localparam logic [THR_W-1:0] THR_RESET = 8'd3;

    typedef enum logic [1:0] {
        TREND_STABLE     = 2'd0,
        TREND_ASCENDING  = 2'd1,
        TREND_DESCENDING = 2'd2
    } trend_t;

    // Direction of one neighbor pair, older to newer.
    typedef struct packed {
        logic rise;
        logic fall;
    } pair_t;

endpackage

`default_nettype wire

// ----- hdl/altitude_trend_detector_unit.sv -----
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  --------------------------------
// input     in         in_valid/in_ready    altitude  (32b signed Q16.16)
// output    out        out_valid/out_ready  trend     (2b: 0 stable, 1 up, 2 down)
// config    in         cfg_we               cfg_wdata (8b threshold, reset 3)
//
// One request per clock: the request is scored in the cycle it is accepted and
// its trend lands in the output register at that edge.
// in_ready is high while the output register is empty or being drained, so a
// stalled output holds off the next request until its trend is taken.
// Reset clears the window (all samples zero), pair counts, run counters and the
// output valid; the threshold returns to 3. No clearing pass is needed.
// out_valid rises in the cycle after a request is accepted.
`default_nettype none

module altitude_trend_detector_unit
    import atd_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [THR_W-1:0]           cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [SAMPLE_W-1:0] altitude,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      trend
);

    // The window is kept as the newest sample plus a chain of pair
    // directions, newest pair first. Only the newest sample is ever
    // compared; older pair directions just shift down the chain.
    logic signed [SAMPLE_W-1:0] newest_reg;
    pair_t                      pair_new;
    pair_t                      pair_chain [PAIRS];
    logic                       take;
    trend_t                     trend_q;

    assign take = in_valid && in_ready;

    // Compare the incoming sample against the current newest one.
    assign pair_new.rise = newest_reg < altitude;
    assign pair_new.fall = altitude < newest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg <= '0;
        end
        else if (take)
        begin
            newest_reg <= altitude;
        end
    end

    for (genvar k = 0; k < PAIRS; k++)
    begin : g_chain
        if (k == 0)
        begin : g_head
            atd_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (take),
                .pair_in  (pair_new),
                .pair_out (pair_chain[k])
            );
        end
        else
        begin : g_body
            atd_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (take),
                .pair_in  (pair_chain[k-1]),
                .pair_out (pair_chain[k])
            );
        end
    end

    // The last cell holds the oldest pair, which drops out on the next shift.
    atd_trend u_trend (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .shift_en   (take),
        .pair_new   (pair_new),
        .pair_old   (pair_chain[PAIRS-1]),
        .take_ready (in_ready),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res_trend  (trend_q)
    );

    assign trend = trend_q;

endmodule

`default_nettype wire

// ----- hdl/atd_cell.sv -----
`default_nettype none

// One stage of the pair chain: holds the direction of one neighbor pair.
module atd_cell
    import atd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  shift_en,
    input  wire pair_t pair_in,
    output pair_t      pair_out
);

    pair_t pair_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg <= '0;
        end
        else if (shift_en)
        begin
            pair_reg <= pair_in;
        end
    end

    assign pair_out = pair_reg;

endmodule

`default_nettype wire

// ----- hdl/atd_trend.sv -----
`default_nettype none

`include "altitude_trend_detector_unit_macros.svh"

// Running pair counts, run counters, threshold register and result register.
module atd_trend
    import atd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [THR_W-1:0] cfg_wdata,
    input  wire logic             shift_en,
    input  wire pair_t            pair_new,
    input  wire pair_t            pair_old,
    output logic                  take_ready,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output trend_t                res_trend
);

    logic [THR_W-1:0] thr_reg;
    logic [CNT_W-1:0] rise_cnt_reg, rise_cnt_next;
    logic [CNT_W-1:0] fall_cnt_reg, fall_cnt_next;
    logic [RUN_W-1:0] rise_run_reg, rise_run_next;
    logic [RUN_W-1:0] fall_run_reg, fall_run_next;
    logic             valid_reg, valid_next;
    trend_t           trend_reg, trend_next;

    // Entering pair adds, pair falling off the old end subtracts.
    assign rise_cnt_next = rise_cnt_reg + CNT_W'(pair_new.rise) - CNT_W'(pair_old.rise);
    assign fall_cnt_next = fall_cnt_reg + CNT_W'(pair_new.fall) - CNT_W'(pair_old.fall);

    always_comb
    begin
        if (THR_W'(rise_cnt_next) >= thr_reg)
        begin
            rise_run_next = (rise_run_reg == RUN_MAX) ? RUN_MAX : rise_run_reg + 1'b1;
        end
        else
        begin
            rise_run_next = '0;
        end

        if (THR_W'(fall_cnt_next) >= thr_reg)
        begin
            fall_run_next = (fall_run_reg == RUN_MAX) ? RUN_MAX : fall_run_reg + 1'b1;
        end
        else
        begin
            fall_run_next = '0;
        end

        if (rise_run_next >= thr_reg)
        begin
            trend_next = TREND_ASCENDING;
        end
        else if (fall_run_next >= thr_reg)
        begin
            trend_next = TREND_DESCENDING;
        end
        else
        begin
            trend_next = TREND_STABLE;
        end
    end

    assign take_ready = !valid_reg || res_ready;
    assign valid_next = shift_en ? 1'b1 : (res_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THR_RESET;
            rise_cnt_reg <= '0;
            fall_cnt_reg <= '0;
            rise_run_reg <= '0;
            fall_run_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (shift_en)
            begin
                rise_cnt_reg <= rise_cnt_next;
                fall_cnt_reg <= fall_cnt_next;
                rise_run_reg <= rise_run_next;
                fall_run_reg <= fall_run_next;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            trend_reg <= trend_next;
        end
    end

    assign res_valid = valid_reg;
    assign res_trend = trend_reg;

    `ATD_ASSERT_ALWAYS(a_pair_total, (THR_W'(rise_cnt_reg) + THR_W'(fall_cnt_reg)) <= THR_W'(PAIRS), "rise plus fall pair count exceeds pairs in window")
    `ATD_ASSERT_NEXT(a_take_shows, shift_en, valid_reg, "accepted request left no result")
    `ATD_ASSERT_IMPL(a_asc_run, valid_reg && (trend_reg == TREND_ASCENDING), rise_run_reg != '0, "ascending result with empty rise run")
    `ATD_ASSERT_IMPL(a_desc_run, valid_reg && (trend_reg == TREND_DESCENDING), fall_run_reg != '0, "descending result with empty fall run")

endmodule

`default_nettype wire
